>>> src/fbcc_pkg.sv
`timescale 1ns / 1ps

package fbcc_pkg;

   // Ring size and derived widths.
   localparam int MAX_ENTRIES = 32;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

   // Field widths.
   localparam int ID_W   = 16;
   localparam int SIZE_W = 32;
   localparam int CAP_W  = 40;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1048576);

   // One request item.
   typedef struct packed {
      logic [ID_W-1:0]   object_id;
      logic [SIZE_W-1:0] object_size;
   } req_type;

   // One result item.
   typedef struct packed {
      logic              is_eviction;
      logic [ID_W-1:0]   evicted_id;
      logic [SIZE_W-1:0] evicted_size;
      logic              hit;
      logic              too_large;
      logic [CAP_W-1:0]  bytes_in_use;
      logic              last;
   } rsp_type;

   // Contents of one cell of the ring.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // Controls sent from the sequencer to the row of cells.
   typedef struct packed {
      logic              rotate;
      logic              load;
      logic [SLOT_W-1:0] load_slot;
      entry_type         load_entry;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESOLVE
   } state_type;

endpackage

>>> src/fbcc_cell.sv
`timescale 1ns / 1ps

module fbcc_cell (
   input  logic                 clock,
   input  logic                 shift_en,
   input  logic                 load_en,
   input  fbcc_pkg::entry_type  nbr_entry,
   input  fbcc_pkg::entry_type  load_entry,
   output fbcc_pkg::entry_type  entry
);
   import fbcc_pkg::*;

   entry_type entry_ff;

   // A cell is written with a new entry, else takes its neighbor's entry on a shift.
   always_ff @(posedge clock) begin
      if (load_en) begin
         entry_ff <= load_entry;
      end else if (shift_en) begin
         entry_ff <= nbr_entry;
      end
   end

   assign entry = entry_ff;

endmodule

>>> src/fbcc_chain.sv
`timescale 1ns / 1ps

module fbcc_chain (
   input  logic                     clock,
   input  fbcc_pkg::chain_ctrl_type ctrl,
   output fbcc_pkg::entry_type      head
);
   import fbcc_pkg::*;

   entry_type cell_out [MAX_ENTRIES];

   // The cells form a ring; on a rotate every cell takes the entry of the
   // cell after it, so between items the oldest entry is found at cell zero.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_ENTRIES;

      fbcc_cell u_cell (
         .clock      (clock),
         .shift_en   (ctrl.rotate),
         .load_en    (ctrl.load && (ctrl.load_slot == SLOT_W'(i))),
         .nbr_entry  (cell_out[NEXT]),
         .load_entry (ctrl.load_entry),
         .entry      (cell_out[i])
      );
   end

   assign head = cell_out[0];

endmodule

>>> src/fifo_byte_capacity_cache_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Contents
// req      in         req_valid/req_ready    object id and size
// rsp      out        rsp_valid/rsp_ready    eviction or final result
// csr      in         csr_wr_en              capacity in bytes
//
// An item is accepted in idle and searched while the whole ring of cells
// rotates once, one entry past the compare at the head per cycle. It is then
// resolved with one more rotate for each eviction before its final result.
// Reset (synchronous) empties the list and restores the default capacity.
// A stalled result holds the sequencer.

module fifo_byte_capacity_cache_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  fbcc_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output fbcc_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [fbcc_pkg::CAP_W-1:0]   csr_wr_data
);
   import fbcc_pkg::*;

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    step_ff, step_in;
   logic                 hit_ff, hit_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CAP_W-1:0]     bytes_ff, bytes_in;
   logic [CAP_W-1:0]     cap_ff;
   req_type              req_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   chain_ctrl_type       ctrl;
   entry_type            head;
   logic                 slot_free;
   logic [CAP_W:0]       sum_bytes;
   logic                 over_cap;
   logic                 too_large;
   logic                 evict_now;
   logic [CAP_W-1:0]     head_size_ext;

   // Ring of cells holding the entries, oldest at the head.
   fbcc_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .head  (head)
   );

   // Fit checks against the capacity.
   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign sum_bytes     = {1'b0, bytes_ff} + (CAP_W + 1)'(req_ff.object_size);
   assign over_cap      = sum_bytes > {1'b0, cap_ff};
   assign too_large     = CAP_W'(req_ff.object_size) > cap_ff;
   assign evict_now     = (count_ff != '0) &&
                          (over_cap || (count_ff == COUNT_W'(MAX_ENTRIES)));
   assign head_size_ext = CAP_W'(head.size);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         hit_ff       <= hit_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // Sequencer: accept, search the ring, then evict and close the item.
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      hit_in           = hit_ff;
      count_in         = count_ff;
      bytes_in         = bytes_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      req_ready        = 1'b0;
      ctrl             = '0;
      ctrl.load_slot   = count_ff[SLOT_W-1:0];
      ctrl.load_entry  = '{id: req_ff.object_id, size: req_ff.object_size};

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               step_in  = '0;
               hit_in   = 1'b0;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // A full turn of the ring leaves the entries in their old order.
            ctrl.rotate = 1'b1;
            if ((COUNT_W'(step_ff) < count_ff) && (head.id == req_ff.object_id)) begin
               hit_in = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == SLOT_W'(MAX_ENTRIES - 1)) begin
               state_in = ST_RESOLVE;
            end
         end

         ST_RESOLVE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (hit_ff) begin
                  rsp_in.hit          = 1'b1;
                  rsp_in.bytes_in_use = bytes_ff;
                  rsp_in.last         = 1'b1;
                  state_in            = ST_IDLE;
               end else if (evict_now) begin
                  // Drop the oldest entry and report it.
                  ctrl.rotate = 1'b1;
                  count_in    = count_ff - 1'b1;
                  bytes_in    = (bytes_ff >= head_size_ext) ?
                                (bytes_ff - head_size_ext) : '0;
                  rsp_in.is_eviction  = 1'b1;
                  rsp_in.evicted_id   = head.id;
                  rsp_in.evicted_size = head.size;
                  rsp_in.bytes_in_use = bytes_in;
               end else if (too_large) begin
                  bytes_in            = '0;
                  rsp_in.too_large    = 1'b1;
                  rsp_in.bytes_in_use = '0;
                  rsp_in.last         = 1'b1;
                  state_in            = ST_IDLE;
               end else begin
                  // Append the new object as the newest entry.
                  ctrl.load           = 1'b1;
                  count_in            = count_ff + 1'b1;
                  bytes_in            = sum_bytes[CAP_W-1:0];
                  rsp_in.bytes_in_use = sum_bytes[CAP_W-1:0];
                  rsp_in.last         = 1'b1;
                  state_in            = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The live count never exceeds the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ENTRIES))
      else $error("entry count beyond ring size");

   // An accepted item always starts a search.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SEARCH))
      else $error("accepted item did not start a search");

   // Each eviction removes exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE && slot_free && !hit_ff && evict_now)
         |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("eviction did not remove one entry");

   // An eviction result is never the final result of an item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_eviction) |-> !rsp_ff.last)
      else $error("eviction result marked last");

   // The ring is not touched while the cache is waiting for a request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!ctrl.rotate && !ctrl.load))
      else $error("ring changed while idle");

endmodule
